[rtl/apfa_pkg.sv]
// ----------------------------------------------------------------------------
// apfa_pkg
// Shared widths, constants and types of the four-anode anger position block.
// ----------------------------------------------------------------------------
package apfa_pkg;

    localparam int ENERGY_BITS   = 16;
    localparam int FRACTION_BITS = 4;

    localparam int NUM_ANODES   = 4;
    localparam int ANODE_IDX_W  = 2;
    localparam int CHAN_W       = 4;
    localparam int PAIR_W       = ENERGY_BITS + 1;
    localparam int TOTAL_W      = ENERGY_BITS + 2;
    localparam int HALF_W       = ENERGY_BITS + 1;

    // coordinate = floor(pair * (512 << F) / total) + (100 << F)
    localparam int SCALE_SHIFT  = 9 + FRACTION_BITS;
    localparam int QUO_W        = SCALE_SHIFT + 1;
    localparam int COORD_W      = 14;
    localparam int COORD_OFFSET = 100 << FRACTION_BITS;
    localparam int COORD_TOP    = (512 + 100) << FRACTION_BITS;

    localparam int THR_W        = 16;
    localparam int SLOPE_W      = 16;
    localparam int ICPT_W       = 22;
    localparam int GATE_W       = 14;
    localparam int PROD_W       = SLOPE_W + COORD_W;
    localparam int PIX_SHIFT    = 16 + FRACTION_BITS;
    localparam int PIX_W        = 7;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 22;

    localparam logic [THR_W-1:0]   RST_THRESHOLD = THR_W'(260);
    localparam logic [SLOPE_W-1:0] RST_SLOPE     = SLOPE_W'(3972);
    localparam logic [ICPT_W-1:0]  RST_ICPT      = ICPT_W'(663880);
    localparam logic [GATE_W-1:0]  RST_GX_LO     = GATE_W'(5456);
    localparam logic [GATE_W-1:0]  RST_GX_HI     = GATE_W'(5696);
    localparam logic [GATE_W-1:0]  RST_GY_LO     = GATE_W'(3200);
    localparam logic [GATE_W-1:0]  RST_GY_HI     = GATE_W'(3376);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SLOPE     = 3'd1,
        CFG_ICPT      = 3'd2,
        CFG_GX_LO     = 3'd3,
        CFG_GX_HI     = 3'd4,
        CFG_GY_LO     = 3'd5,
        CFG_GY_HI     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]   energy_threshold;
        logic [SLOPE_W-1:0] pixel_slope;
        logic [ICPT_W-1:0]  pixel_intercept;
        logic [GATE_W-1:0]  gate_x_low;
        logic [GATE_W-1:0]  gate_x_high;
        logic [GATE_W-1:0]  gate_y_low;
        logic [GATE_W-1:0]  gate_y_high;
    } t_cfg;

    // anode energies after one hit, handed from front to back
    typedef struct packed {
        logic [NUM_ANODES-1:0][ENERGY_BITS-1:0] anode;
    } t_snap;

    typedef struct packed {
        logic  push;
        t_snap snap;
    } t_push;

endpackage

[rtl/apfa_front.sv]
// ----------------------------------------------------------------------------
// apfa_front
// Accepts channel hits, classifies the channel and keeps the anode energies.
// ----------------------------------------------------------------------------
module apfa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_first_of_event,
    input  logic [apfa_pkg::CHAN_W-1:0]   i_channel,
    input  logic [apfa_pkg::ENERGY_BITS-1:0] i_energy,
    input  logic                          i_full,
    output apfa_pkg::t_push               o_push
);
    import apfa_pkg::*;

    logic [NUM_ANODES-1:0][ENERGY_BITS-1:0] r_anode;
    logic [NUM_ANODES-1:0][ENERGY_BITS-1:0] n_anode;
    logic                                   is_anode;
    logic                                   accept;

    // dynode and unused channels leave the anode energies alone, but for the first_of_event clear
    assign is_anode = i_channel < CHAN_W'(NUM_ANODES);
    assign accept   = i_valid && !i_full;
    assign o_ready  = !i_full;

    always_comb begin
        for (int j = 0; j < NUM_ANODES; j++) begin
            n_anode[j] = i_first_of_event ? '0 : r_anode[j];
            if (is_anode && (i_channel[ANODE_IDX_W-1:0] == ANODE_IDX_W'(j))) begin
                n_anode[j] = i_energy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anode <= '0;
        end else if (accept) begin
            r_anode <= n_anode;
        end
    end

    assign o_push.push       = accept;
    assign o_push.snap.anode = n_anode;

endmodule

[rtl/apfa_queue.sv]
// ----------------------------------------------------------------------------
// apfa_queue
// Two-entry queue of anode snapshots between front and back.
// ----------------------------------------------------------------------------
module apfa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apfa_pkg::t_push   i_push,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output apfa_pkg::t_snap   o_snap
);
    import apfa_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_snap            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_pop  = i_pop && !o_empty;
    assign o_snap  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({i_push.push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/apfa_back.sv]
// ----------------------------------------------------------------------------
// apfa_back
// Computes sums, coordinates by a shared radix-2 divider, pixels and gate.
// ----------------------------------------------------------------------------
module apfa_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  apfa_pkg::t_cfg                        i_cfg,
    input  logic                                  i_empty,
    input  apfa_pkg::t_snap                       i_snap,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_position_valid,
    output logic                                  o_above_threshold,
    output logic [apfa_pkg::HALF_W-1:0]           o_half_sum,
    output logic [apfa_pkg::COORD_W-1:0]          o_x_right,
    output logic [apfa_pkg::COORD_W-1:0]          o_x_left,
    output logic [apfa_pkg::COORD_W-1:0]          o_y_top,
    output logic [apfa_pkg::COORD_W-1:0]          o_y_bottom,
    output logic signed [apfa_pkg::PIX_W-1:0]     o_pixel_x_right,
    output logic signed [apfa_pkg::PIX_W-1:0]     o_pixel_x_left,
    output logic signed [apfa_pkg::PIX_W-1:0]     o_pixel_y_top,
    output logic signed [apfa_pkg::PIX_W-1:0]     o_pixel_y_bottom,
    output logic                                  o_in_gate
);
    import apfa_pkg::*;

    localparam int REM_W   = TOTAL_W + 1;
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int PK_W    = 3;
    localparam int MAG_W   = PROD_W - PIX_SHIFT;
    localparam int PIX_MAX = (1 << (PIX_W - 1)) - 1;
    localparam int PIX_NEG = 1 << (PIX_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIVX,
        S_DIVY,
        S_COORD,
        S_PIX,
        S_DONE
    } t_state;

    t_state                                  r_state;
    logic [NUM_ANODES-1:0][ENERGY_BITS-1:0]  r_a;
    logic [TOTAL_W-1:0]                      r_total;
    logic [PAIR_W-1:0]                       r_pair_y;
    logic                                    r_pos_valid;
    logic                                    r_above;
    logic [TOTAL_W-1:0]                      r_rem;
    logic [QUO_W-1:0]                        r_quo;
    logic                                    r_feed;
    logic [STEP_W-1:0]                       r_step;
    logic [QUO_W-1:0]                        r_quo_x;
    logic                                    r_nz_x;
    logic [NUM_ANODES-1:0][COORD_W-1:0]      r_coord;
    logic [PROD_W-1:0]                       r_prod;
    logic [NUM_ANODES-1:0][PIX_W-1:0]        r_pix;
    logic [PK_W-1:0]                         r_pk;
    logic                                    r_out_valid;

    logic [PAIR_W-1:0]      pair_x;
    logic [PAIR_W-1:0]      pair_l;
    logic [PAIR_W-1:0]      pair_y;
    logic [TOTAL_W-1:0]     total;
    logic                   all_nonzero;
    logic                   all_above;
    logic [REM_W-1:0]       trial;
    logic                   fits;
    logic [TOTAL_W-1:0]     n_rem;
    logic [QUO_W-1:0]       n_quo;
    logic                   n_nz;
    logic [PROD_W-1:0]      offset;
    logic                   neg;
    logic [PROD_W-1:0]      mag;
    logic [MAG_W-1:0]       mag_hi;
    logic [PIX_W-1:0]       n_pix;
    logic [ANODE_IDX_W-1:0] mul_idx;
    logic [ANODE_IDX_W-1:0] pix_idx;
    logic                   gate;
    logic                   load_out;

    assign pair_x = PAIR_W'(r_a[3]) + PAIR_W'(r_a[0]);
    assign pair_l = PAIR_W'(r_a[1]) + PAIR_W'(r_a[2]);
    assign pair_y = PAIR_W'(r_a[0]) + PAIR_W'(r_a[1]);
    assign total  = TOTAL_W'(pair_x) + TOTAL_W'(pair_l);

    always_comb begin
        all_nonzero = 1'b1;
        all_above   = 1'b1;
        for (int j = 0; j < NUM_ANODES; j++) begin
            all_nonzero = all_nonzero && (r_a[j] != '0);
            all_above   = all_above && (THR_W'(r_a[j]) > i_cfg.energy_threshold);
        end
    end

    // one restoring division step; remainder stays below the total
    assign trial = {r_rem, r_feed};
    assign fits  = trial >= REM_W'(r_total);
    assign n_rem = fits ? TOTAL_W'(trial - REM_W'(r_total)) : trial[TOTAL_W-1:0];
    assign n_quo = {r_quo[QUO_W-2:0], fits};
    assign n_nz  = n_rem != '0;

    // pixel: (slope * coord - intercept << F) >> (16 + F), toward zero, saturated
    assign offset = PROD_W'(i_cfg.pixel_intercept) << FRACTION_BITS;
    assign neg    = r_prod < offset;
    assign mag    = neg ? (offset - r_prod) : (r_prod - offset);
    assign mag_hi = mag[PROD_W-1:PIX_SHIFT];

    always_comb begin
        if (neg) begin
            n_pix = (mag_hi > MAG_W'(PIX_NEG)) ? PIX_W'(PIX_NEG)
                                               : PIX_W'(0) - mag_hi[PIX_W-1:0];
        end else begin
            n_pix = (mag_hi > MAG_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : mag_hi[PIX_W-1:0];
        end
    end

    assign mul_idx = r_pk[ANODE_IDX_W-1:0];
    assign pix_idx = r_pk[ANODE_IDX_W-1:0] - ANODE_IDX_W'(1);

    assign gate = r_above &&
                  (r_coord[0] > i_cfg.gate_x_low) && (r_coord[0] < i_cfg.gate_x_high) &&
                  (r_coord[2] > i_cfg.gate_y_low) && (r_coord[2] < i_cfg.gate_y_high);

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_out_valid;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_a     <= i_snap.anode;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_total     <= total;
                    r_pair_y    <= pair_y;
                    r_pos_valid <= all_nonzero;
                    r_above     <= all_above;
                    r_rem       <= TOTAL_W'(pair_x >> 1);
                    r_feed      <= pair_x[0];
                    r_quo       <= '0;
                    r_step      <= '0;
                    r_state     <= all_nonzero ? S_DIVX : S_DONE;
                end
                S_DIVX: begin
                    if (r_step == STEP_W'(QUO_W - 1)) begin
                        // start the second ratio with the top pair
                        r_quo_x <= n_quo;
                        r_nz_x  <= n_nz;
                        r_rem   <= TOTAL_W'(r_pair_y >> 1);
                        r_feed  <= r_pair_y[0];
                        r_quo   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIVY;
                    end else begin
                        r_rem  <= n_rem;
                        r_quo  <= n_quo;
                        r_feed <= 1'b0;
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DIVY: begin
                    if (r_step == STEP_W'(QUO_W - 1)) begin
                        r_quo   <= n_quo;
                        r_feed  <= n_nz;
                        r_state <= S_COORD;
                    end else begin
                        r_rem  <= n_rem;
                        r_quo  <= n_quo;
                        r_feed <= 1'b0;
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_COORD: begin
                    // complementary pair: floor((T-p)k/T) = k - ceil(pk/T)
                    r_coord[0] <= COORD_W'(r_quo_x) + COORD_W'(COORD_OFFSET);
                    r_coord[1] <= COORD_W'(COORD_TOP) - COORD_W'(r_quo_x)
                                  - COORD_W'(r_nz_x);
                    r_coord[2] <= COORD_W'(r_quo) + COORD_W'(COORD_OFFSET);
                    r_coord[3] <= COORD_W'(COORD_TOP) - COORD_W'(r_quo)
                                  - COORD_W'(r_feed);
                    r_pk       <= '0;
                    r_state    <= r_above ? S_PIX : S_DONE;
                end
                S_PIX: begin
                    // multiply one coordinate while converting the previous product
                    r_prod <= PROD_W'(i_cfg.pixel_slope) * PROD_W'(r_coord[mul_idx]);
                    if (r_pk != '0) begin
                        r_pix[pix_idx] <= n_pix;
                    end
                    r_pk <= r_pk + PK_W'(1);
                    if (r_pk == PK_W'(NUM_ANODES)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        o_position_valid  <= r_pos_valid;
                        o_above_threshold <= r_pos_valid && r_above;
                        o_half_sum        <= r_pos_valid ? r_total[TOTAL_W-1:1] : '0;
                        o_x_right         <= r_pos_valid ? r_coord[0] : '0;
                        o_x_left          <= r_pos_valid ? r_coord[1] : '0;
                        o_y_top           <= r_pos_valid ? r_coord[2] : '0;
                        o_y_bottom        <= r_pos_valid ? r_coord[3] : '0;
                        o_pixel_x_right   <= (r_pos_valid && r_above) ? r_pix[0] : '0;
                        o_pixel_x_left    <= (r_pos_valid && r_above) ? r_pix[1] : '0;
                        o_pixel_y_top     <= (r_pos_valid && r_above) ? r_pix[2] : '0;
                        o_pixel_y_bottom  <= (r_pos_valid && r_above) ? r_pix[3] : '0;
                        o_in_gate         <= r_pos_valid && gate;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/anger_position_four_anode.sv]
// ----------------------------------------------------------------------------
// anger_position_four_anode
// Anger-logic position of a four-anode photomultiplier from channel hits.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: one hit per beat (first_of_event, channel, energy) on
//   i_valid / o_ready. Channels 0-3 update the stored anode energies;
//   first_of_event clears them first. Every beat yields one result beat on
//   o_valid / i_ready with the sums, coordinates, pixels and gate flag.
//   config channel: i_cfg_valid / o_cfg_ready with a register index and data;
//   always ready, write only while no hit is in flight.
// Back end: a hit with all four anodes above threshold runs in the back end
//   through two 14-step ratios on one shared radix-2 divider, then four
//   pixel multiplies on one multiplier; one with all four anodes set but
//   some at or below threshold skips the pixel multiplies, and one missing
//   an anode skips the divider too. The back end takes the next hit from
//   the queue only after its last result is loaded into the output register.
// The front end keeps taking hits while its two-entry queue has room, also
//   while a result waits in the output register for a stalled receiver.
// Reset clears the anode energies, the queue and the output valid, and loads
//   the register defaults.
// ----------------------------------------------------------------------------
module anger_position_four_anode (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [apfa_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [apfa_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_first_of_event,
    input  logic [apfa_pkg::CHAN_W-1:0]            i_channel,
    input  logic [apfa_pkg::ENERGY_BITS-1:0]       i_energy,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_position_valid,
    output logic                                   o_above_threshold,
    output logic [apfa_pkg::HALF_W-1:0]            o_half_sum,
    output logic [apfa_pkg::COORD_W-1:0]           o_x_right,
    output logic [apfa_pkg::COORD_W-1:0]           o_x_left,
    output logic [apfa_pkg::COORD_W-1:0]           o_y_top,
    output logic [apfa_pkg::COORD_W-1:0]           o_y_bottom,
    output logic signed [apfa_pkg::PIX_W-1:0]      o_pixel_x_right,
    output logic signed [apfa_pkg::PIX_W-1:0]      o_pixel_x_left,
    output logic signed [apfa_pkg::PIX_W-1:0]      o_pixel_y_top,
    output logic signed [apfa_pkg::PIX_W-1:0]      o_pixel_y_bottom,
    output logic                                   o_in_gate
);
    import apfa_pkg::*;

    t_cfg  r_cfg;
    t_push push;
    t_snap snap;
    logic  full;
    logic  empty;
    logic  pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.energy_threshold <= RST_THRESHOLD;
            r_cfg.pixel_slope      <= RST_SLOPE;
            r_cfg.pixel_intercept  <= RST_ICPT;
            r_cfg.gate_x_low       <= RST_GX_LO;
            r_cfg.gate_x_high      <= RST_GX_HI;
            r_cfg.gate_y_low       <= RST_GY_LO;
            r_cfg.gate_y_high      <= RST_GY_HI;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_cfg.energy_threshold <= i_cfg_data[THR_W-1:0];
                CFG_SLOPE:     r_cfg.pixel_slope      <= i_cfg_data[SLOPE_W-1:0];
                CFG_ICPT:      r_cfg.pixel_intercept  <= i_cfg_data[ICPT_W-1:0];
                CFG_GX_LO:     r_cfg.gate_x_low       <= i_cfg_data[GATE_W-1:0];
                CFG_GX_HI:     r_cfg.gate_x_high      <= i_cfg_data[GATE_W-1:0];
                CFG_GY_LO:     r_cfg.gate_y_low       <= i_cfg_data[GATE_W-1:0];
                CFG_GY_HI:     r_cfg.gate_y_high      <= i_cfg_data[GATE_W-1:0];
                default:       r_cfg                  <= r_cfg;
            endcase
        end
    end

    apfa_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_first_of_event (i_first_of_event),
        .i_channel        (i_channel),
        .i_energy         (i_energy),
        .i_full           (full),
        .o_push           (push)
    );

    apfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_snap  (snap)
    );

    apfa_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_empty           (empty),
        .i_snap            (snap),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_position_valid  (o_position_valid),
        .o_above_threshold (o_above_threshold),
        .o_half_sum        (o_half_sum),
        .o_x_right         (o_x_right),
        .o_x_left          (o_x_left),
        .o_y_top           (o_y_top),
        .o_y_bottom        (o_y_bottom),
        .o_pixel_x_right   (o_pixel_x_right),
        .o_pixel_x_left    (o_pixel_x_left),
        .o_pixel_y_top     (o_pixel_y_top),
        .o_pixel_y_bottom  (o_pixel_y_bottom),
        .o_in_gate         (o_in_gate)
    );

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-anode anger position block. Channel hits
// are sent as events, either whole anode sets or broken and noisy ones, while
// an in-bench model tracks the stored energies and predicts every result beat.
// The register settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

    import apfa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE   = 3'd7;
    localparam logic [CHAN_W-1:0]    DYNODE_CH  = 4'd4;
    localparam logic [CHAN_W-1:0]    LAST_CH    = 4'd15;
    localparam int                   SETTLE_CYC = 40;
    localparam int                   PHASE_HITS = 200;

    typedef struct packed {
        logic                     position_valid;
        logic                     above_threshold;
        logic [HALF_W-1:0]        half_sum;
        logic [COORD_W-1:0]       x_right;
        logic [COORD_W-1:0]       x_left;
        logic [COORD_W-1:0]       y_top;
        logic [COORD_W-1:0]       y_bottom;
        logic signed [PIX_W-1:0]  pixel_x_right;
        logic signed [PIX_W-1:0]  pixel_x_left;
        logic signed [PIX_W-1:0]  pixel_y_top;
        logic signed [PIX_W-1:0]  pixel_y_bottom;
        logic                     in_gate;
    } t_position;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} t_rx_mode;
    typedef enum int {EV_FULL, EV_PARTIAL, EV_NOISE, EV_CONTINUE} t_event_kind;

    // tracks stored energies and registers, holds the positions still due
    class position_tracker;
        t_cfg                   settings;
        logic [ENERGY_BITS-1:0] anode [NUM_ANODES];
        logic [ENERGY_BITS-1:0] dynode;
        t_position              pending_positions[$];
        int errors;
        int results;
        int thresholded;
        int gated;

        function new();
            settings.energy_threshold = RST_THRESHOLD;
            settings.pixel_slope      = RST_SLOPE;
            settings.pixel_intercept  = RST_ICPT;
            settings.gate_x_low       = RST_GX_LO;
            settings.gate_x_high      = RST_GX_HI;
            settings.gate_y_low       = RST_GY_LO;
            settings.gate_y_high      = RST_GY_HI;
            foreach (anode[i]) anode[i] = '0;
            dynode      = '0;
            errors      = 0;
            results     = 0;
            thresholded = 0;
            gated       = 0;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: settings.energy_threshold = data[THR_W-1:0];
                CFG_SLOPE:     settings.pixel_slope      = data[SLOPE_W-1:0];
                CFG_ICPT:      settings.pixel_intercept  = data[ICPT_W-1:0];
                CFG_GX_LO:     settings.gate_x_low       = data[GATE_W-1:0];
                CFG_GX_HI:     settings.gate_x_high      = data[GATE_W-1:0];
                CFG_GY_LO:     settings.gate_y_low       = data[GATE_W-1:0];
                CFG_GY_HI:     settings.gate_y_high      = data[GATE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned coord_of(longint unsigned pair, longint unsigned total);
            return ((pair << SCALE_SHIFT) / total) + COORD_OFFSET;
        endfunction

        function logic signed [PIX_W-1:0] pixel_of(longint unsigned coord);
            longint unsigned prod;
            longint unsigned off;
            longint unsigned mag;
            logic            neg;
            prod = settings.pixel_slope * coord;
            off  = settings.pixel_intercept;
            off  = off << FRACTION_BITS;
            neg  = prod < off;
            mag  = neg ? (off - prod) : (prod - off);
            mag  = mag >> PIX_SHIFT;
            if (neg) begin
                return (mag > 64) ? -7'sd64 : PIX_W'(64'd0 - mag);
            end
            return (mag > 63) ? 7'sd63 : PIX_W'(mag);
        endfunction

        function t_position locate();
            t_position       p;
            longint unsigned a0, a1, a2, a3, total, xr, xl, yt, yb;
            p  = '0;
            a0 = anode[0];
            a1 = anode[1];
            a2 = anode[2];
            a3 = anode[3];
            if (a0 == 0 || a1 == 0 || a2 == 0 || a3 == 0) return p;
            total = a0 + a1 + a2 + a3;
            xr = coord_of(a3 + a0, total);
            xl = coord_of(a1 + a2, total);
            yt = coord_of(a0 + a1, total);
            yb = coord_of(a2 + a3, total);
            p.position_valid  = 1'b1;
            p.above_threshold = a0 > settings.energy_threshold &&
                                a1 > settings.energy_threshold &&
                                a2 > settings.energy_threshold &&
                                a3 > settings.energy_threshold;
            p.half_sum = HALF_W'(total >> 1);
            p.x_right  = COORD_W'(xr);
            p.x_left   = COORD_W'(xl);
            p.y_top    = COORD_W'(yt);
            p.y_bottom = COORD_W'(yb);
            if (p.above_threshold) begin
                p.pixel_x_right  = pixel_of(xr);
                p.pixel_x_left   = pixel_of(xl);
                p.pixel_y_top    = pixel_of(yt);
                p.pixel_y_bottom = pixel_of(yb);
                p.in_gate = xr > settings.gate_x_low && xr < settings.gate_x_high &&
                            yt > settings.gate_y_low && yt < settings.gate_y_high;
            end
            return p;
        endfunction

        function void note_hit(logic fe, logic [CHAN_W-1:0] ch, logic [ENERGY_BITS-1:0] en);
            if (fe) begin
                foreach (anode[i]) anode[i] = '0;
                dynode = '0;
            end
            if (ch < NUM_ANODES) anode[ch[ANODE_IDX_W-1:0]] = en;
            else if (ch == DYNODE_CH) dynode = en;
            pending_positions.push_back(locate());
        endfunction

        function int outstanding();
            return pending_positions.size();
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_position got);
            t_position want;
            if (pending_positions.size() == 0) begin
                errors++;
                $display("%0t: result beat with no hit pending, half_sum %0d",
                         $time, got.half_sum);
                return;
            end
            want = pending_positions.pop_front();
            results++;
            if (want.above_threshold) thresholded++;
            if (want.in_gate) gated++;
            compare_field("position_valid", want.position_valid, got.position_valid);
            compare_field("above_threshold", want.above_threshold, got.above_threshold);
            compare_field("half_sum", want.half_sum, got.half_sum);
            compare_field("x_right", want.x_right, got.x_right);
            compare_field("x_left", want.x_left, got.x_left);
            compare_field("y_top", want.y_top, got.y_top);
            compare_field("y_bottom", want.y_bottom, got.y_bottom);
            compare_field("pixel_x_right", $signed(want.pixel_x_right),
                          $signed(got.pixel_x_right));
            compare_field("pixel_x_left", $signed(want.pixel_x_left),
                          $signed(got.pixel_x_left));
            compare_field("pixel_y_top", $signed(want.pixel_y_top),
                          $signed(got.pixel_y_top));
            compare_field("pixel_y_bottom", $signed(want.pixel_y_bottom),
                          $signed(got.pixel_y_bottom));
            compare_field("in_gate", want.in_gate, got.in_gate);
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n          = 1'b0;
    logic                    i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data       = '0;
    logic                    i_valid          = 1'b0;
    logic                    i_first_of_event = 1'b0;
    logic [CHAN_W-1:0]       i_channel        = '0;
    logic [ENERGY_BITS-1:0]  i_energy         = '0;
    logic                    i_ready          = 1'b0;
    logic                    o_cfg_ready;
    logic                    o_ready;
    logic                    o_valid;
    logic                    o_position_valid;
    logic                    o_above_threshold;
    logic [HALF_W-1:0]       o_half_sum;
    logic [COORD_W-1:0]      o_x_right;
    logic [COORD_W-1:0]      o_x_left;
    logic [COORD_W-1:0]      o_y_top;
    logic [COORD_W-1:0]      o_y_bottom;
    logic signed [PIX_W-1:0] o_pixel_x_right;
    logic signed [PIX_W-1:0] o_pixel_x_left;
    logic signed [PIX_W-1:0] o_pixel_y_top;
    logic signed [PIX_W-1:0] o_pixel_y_bottom;
    logic                    o_in_gate;

    position_tracker board;
    int              hits_sent     = 0;
    int              burst_left    = 1;
    int              settings_used = 1;
    int              rx_cycle      = 0;
    t_rx_mode        rx_mode       = RX_OPEN;

    anger_position_four_anode dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_first_of_event  (i_first_of_event),
        .i_channel         (i_channel),
        .i_energy          (i_energy),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_position_valid  (o_position_valid),
        .o_above_threshold (o_above_threshold),
        .o_half_sum        (o_half_sum),
        .o_x_right         (o_x_right),
        .o_x_left          (o_x_left),
        .o_y_top           (o_y_top),
        .o_y_bottom        (o_y_bottom),
        .o_pixel_x_right   (o_pixel_x_right),
        .o_pixel_x_left    (o_pixel_x_left),
        .o_pixel_y_top     (o_pixel_y_top),
        .o_pixel_y_bottom  (o_pixel_y_bottom),
        .o_in_gate         (o_in_gate)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("timeout with %0d results still due", board.outstanding());
        $display("*** FAILED ***");
        $finish;
    end

    // result side: check each beat, then pick the next ready level
    always @(posedge i_clk) begin
        t_position got;
        if (i_rst_n && o_valid && i_ready) begin
            got.position_valid  = o_position_valid;
            got.above_threshold = o_above_threshold;
            got.half_sum        = o_half_sum;
            got.x_right         = o_x_right;
            got.x_left          = o_x_left;
            got.y_top           = o_y_top;
            got.y_bottom        = o_y_bottom;
            got.pixel_x_right   = o_pixel_x_right;
            got.pixel_x_left    = o_pixel_x_left;
            got.pixel_y_top     = o_pixel_y_top;
            got.pixel_y_bottom  = o_pixel_y_bottom;
            got.in_gate         = o_in_gate;
            board.check_result(got);
        end
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 512 == 0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
            default:   i_ready <= (rx_cycle % 13) < 4;
        endcase
    end

    // leaves i_valid high; the caller either sends again or idles
    task automatic send_hit(logic fe, logic [CHAN_W-1:0] ch, logic [ENERGY_BITS-1:0] en);
        i_valid          <= 1'b1;
        i_first_of_event <= fe;
        i_channel        <= ch;
        i_energy         <= en;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_hit(fe, ch, en);
        hits_sent++;
    endtask

    task automatic idle(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // burst pacing on the hit side
    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            idle(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.apply_config(idx, data);
    endtask

    // upper data bits are junk on the narrow registers
    task automatic configure(logic [THR_W-1:0] thr, logic [SLOPE_W-1:0] slope,
                             logic [ICPT_W-1:0] icpt, logic [GATE_W-1:0] gxl,
                             logic [GATE_W-1:0] gxh, logic [GATE_W-1:0] gyl,
                             logic [GATE_W-1:0] gyh);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        write_reg(CFG_THRESHOLD, {6'($urandom), thr});
        write_reg(CFG_SLOPE, {6'($urandom), slope});
        write_reg(CFG_ICPT, icpt);
        write_reg(CFG_GX_LO, {8'($urandom), gxl});
        write_reg(CFG_GX_HI, {8'($urandom), gxh});
        write_reg(CFG_GY_LO, {8'($urandom), gyl});
        write_reg(CFG_GY_HI, {8'($urandom), gyh});
        write_reg(CFG_NONE, 22'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic configure_random();
        logic [GATE_W-1:0] gxl, gxh, gyl, gyh;
        logic [THR_W-1:0]  thr;
        int                span;
        thr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
        if ($urandom_range(0, 1) == 1) begin
            gxl  = GATE_W'($urandom_range(1500, 6000));
            span = int'(gxl) + $urandom_range(1, 3000);
            gxh  = GATE_W'(span);
            gyl  = GATE_W'($urandom_range(1500, 6000));
            span = int'(gyl) + $urandom_range(1, 3000);
            gyh  = GATE_W'(span);
        end else begin
            gxl = GATE_W'($urandom);
            gxh = GATE_W'($urandom);
            gyl = GATE_W'($urandom);
            gyh = GATE_W'($urandom);
        end
        configure(thr, 16'($urandom), ICPT_W'($urandom), gxl, gxh, gyl, gyh);
    endtask

    function automatic logic [ENERGY_BITS-1:0] pick_energy();
        int sel;
        int t;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: return 16'($urandom);
            3: return ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 15));
            4, 5: begin
                // straddle the current threshold
                t = int'(board.settings.energy_threshold) + $urandom_range(0, 6) - 3;
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                return 16'(t);
            end
            6, 7: return 16'($urandom_range(1, 1000));
            8: return 16'($urandom_range(60000, 65535));
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic send_event();
        t_event_kind kind;
        int          order [NUM_ANODES];
        int          i, j, tmp, n, sel;
        sel  = $urandom_range(0, 9);
        kind = (sel <= 6) ? EV_FULL : (sel == 7) ? EV_PARTIAL :
               (sel == 8) ? EV_NOISE : EV_CONTINUE;
        case (kind)
            EV_FULL: begin
                foreach (order[k]) order[k] = k;
                for (i = NUM_ANODES - 1; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (i = 0; i < NUM_ANODES; i++) begin
                    send_hit(i == 0, CHAN_W'(order[i]), pick_energy());
                    pace();
                    // dynode or stray channel in the middle of the event
                    if ($urandom_range(0, 7) == 0) begin
                        send_hit(1'b0, CHAN_W'($urandom_range(DYNODE_CH, LAST_CH)),
                                 16'($urandom));
                        pace();
                    end
                end
            end
            EV_PARTIAL: begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    send_hit(i == 0, CHAN_W'($urandom_range(0, NUM_ANODES - 1)), pick_energy());
                    pace();
                end
            end
            EV_NOISE: begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    send_hit(1'($urandom), CHAN_W'($urandom), 16'($urandom));
                    pace();
                end
            end
            default: begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    send_hit(1'b0, CHAN_W'($urandom_range(0, NUM_ANODES - 1)), pick_energy());
                    pace();
                end
            end
        endcase
    endtask

    task automatic run_hits(int count);
        int  start;
        logic paused;
        start  = hits_sent;
        paused = 1'b0;
        while (hits_sent - start < count) begin
            send_event();
            // hold the sender once until the block has emptied
            if (!paused && hits_sent - start >= count / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    task automatic send_directed();
        // cleared start, then all anodes at full scale
        send_hit(1'b1, 4'd0, 16'hFFFF);
        send_hit(1'b0, 4'd1, 16'hFFFF);
        send_hit(1'b0, 4'd2, 16'hFFFF);
        send_hit(1'b0, 4'd3, 16'hFFFF);
        pace();
        // dynode and unused channel leave the position alone
        send_hit(1'b0, DYNODE_CH, 16'd12345);
        send_hit(1'b0, LAST_CH, 16'hFFFF);
        pace();
        // smallest energies, below threshold
        send_hit(1'b1, 4'd0, 16'd1);
        send_hit(1'b0, 4'd1, 16'd1);
        send_hit(1'b0, 4'd2, 16'd1);
        send_hit(1'b0, 4'd3, 16'd1);
        send_hit(1'b0, 4'd2, 16'd0);
        pace();
        // lopsided event, coordinates near both ends
        send_hit(1'b1, 4'd3, 16'hFFFF);
        send_hit(1'b0, 4'd0, 16'hFFFF);
        send_hit(1'b0, 4'd1, 16'd1);
        send_hit(1'b0, 4'd2, 16'd1);
        // inside the reset gate window
        send_hit(1'b1, 4'd0, 16'd1000);
        send_hit(1'b0, 4'd1, 16'd1060);
        send_hit(1'b0, 4'd2, 16'd4086);
        send_hit(1'b0, 4'd3, 16'd3854);
        pace();
        // one anode exactly at threshold, then just over
        send_hit(1'b1, 4'd0, RST_THRESHOLD);
        send_hit(1'b0, 4'd1, RST_THRESHOLD + 16'd1);
        send_hit(1'b0, 4'd2, RST_THRESHOLD + 16'd1);
        send_hit(1'b0, 4'd3, RST_THRESHOLD + 16'd1);
        send_hit(1'b0, 4'd0, RST_THRESHOLD + 16'd1);
        // clear through an unused channel
        send_hit(1'b1, 4'd7, 16'd5);
        wait_drained();
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();

        configure(16'd0, 16'hFFFF, 22'd0, 14'd0, 14'h3FFF, 14'd0, 14'h3FFF);
        run_hits(PHASE_HITS);
        configure(16'hFFFF, 16'd0, 22'h3FFFFF, 14'h3FFF, 14'd0, 14'h3FFF, 14'd0);
        run_hits(PHASE_HITS);
        configure(16'd0, 16'd0, 22'h3FFFFF, 14'd0, 14'h3FFF, 14'd0, 14'h3FFF);
        run_hits(PHASE_HITS);
        configure(RST_THRESHOLD, RST_SLOPE, RST_ICPT, RST_GX_LO, RST_GX_HI,
                  RST_GY_LO, RST_GY_HI);
        run_hits(PHASE_HITS);
        repeat (4) begin
            configure_random();
            run_hits(PHASE_HITS);
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("sent %0d hits over %0d register settings, checked %0d results",
                 hits_sent, settings_used, board.results);
        $display("%0d results above threshold, %0d inside the gate",
                 board.thresholded, board.gated);
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[anger_position_four_anode.f]
rtl/apfa_pkg.sv
rtl/apfa_front.sv
rtl/apfa_queue.sv
rtl/apfa_back.sv
rtl/anger_position_four_anode.sv
tb/sv/tb.sv
